### design/kgug_pkg.sv
package kgug_pkg;

	localparam int unsigned WORD_W      = 32;
	localparam int unsigned NUM_WORDS   = 12;
	localparam int unsigned NUM_ROUNDS  = 24;
	localparam int unsigned ROUND_W     = 5;
	localparam int unsigned MAX_PERMS   = 256;
	localparam logic [WORD_W-1:0] ROUND_CONST = 32'h9e37_7900;

	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_0      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_1      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_2      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_3      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_LOW  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_HIGH = 3'd5;

	typedef logic [NUM_WORDS-1:0][WORD_W-1:0] gimli_state_t;

	typedef struct packed {
		logic [3:0][63:0] key;
		logic [63:0]      limit_low;
		logic [31:0]      limit_high;
	} cfg_t;

endpackage

### design/kgug_cfg.sv
module kgug_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [kgug_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [63:0]                        cfg_data,
	output kgug_pkg::cfg_t                     cfg
);

	kgug_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.key        <= '0;
			cfg_q.limit_low  <= '1;
			cfg_q.limit_high <= '1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				kgug_pkg::REG_KEY_0:      cfg_q.key[0] <= cfg_data;
				kgug_pkg::REG_KEY_1:      cfg_q.key[1] <= cfg_data;
				kgug_pkg::REG_KEY_2:      cfg_q.key[2] <= cfg_data;
				kgug_pkg::REG_KEY_3:      cfg_q.key[3] <= cfg_data;
				kgug_pkg::REG_LIMIT_LOW:  cfg_q.limit_low <= cfg_data;
				kgug_pkg::REG_LIMIT_HIGH: cfg_q.limit_high <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

endmodule

### design/kgug_round.sv
module kgug_round (
	input  kgug_pkg::gimli_state_t              state_in,
	input  logic [kgug_pkg::ROUND_W-1:0]        round,
	output kgug_pkg::gimli_state_t              state_out
);

	kgug_pkg::gimli_state_t sp;

	// The SP-box acts on each of the four columns independently.
	always_comb begin
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		sp = state_in;
		for (int c = 0; c < 4; c++) begin
			x = {state_in[c][7:0], state_in[c][31:8]};
			y = {state_in[4+c][22:0], state_in[4+c][31:23]};
			z = state_in[8+c];
			sp[8+c] = x ^ {z[30:0], 1'b0} ^ {(y[29:0] & z[29:0]), 2'b00};
			sp[4+c] = y ^ x ^ {(x[30:0] | z[30:0]), 1'b0};
			sp[c]   = z ^ y ^ {(x[28:0] & y[28:0]), 3'b000};
		end
	end

	// Small swap with the round constant every fourth round, big swap two rounds later.
	always_comb begin
		state_out = sp;
		unique case (round[1:0])
			2'd0: begin
				state_out[0] = sp[1] ^ kgug_pkg::ROUND_CONST
					^ {{(kgug_pkg::WORD_W-kgug_pkg::ROUND_W){1'b0}}, round};
				state_out[1] = sp[0];
				state_out[2] = sp[3];
				state_out[3] = sp[2];
			end
			2'd2: begin
				state_out[0] = sp[2];
				state_out[1] = sp[3];
				state_out[2] = sp[0];
				state_out[3] = sp[1];
			end
			default: ;
		endcase
	end

endmodule

### design/kgug_core.sv
module kgug_core #(
	parameter int unsigned MaxPerms = kgug_pkg::MAX_PERMS
) (
	input  logic            clk,
	input  logic            arst_n,
	input  kgug_pkg::cfg_t  cfg,
	input  logic            start,
	output logic            busy,
	input  logic [63:0]     event_number,
	input  logic [31:0]     session_number,
	input  logic [31:0]     board_number,
	output logic            uid_valid,
	output logic [63:0]     uid_low,
	output logic [31:0]     uid_high
);

	localparam int unsigned PermW = (MaxPerms > 1) ? $clog2(MaxPerms) : 1;
	localparam logic [PermW-1:0] LastPerm = PermW'(MaxPerms - 1);
	localparam logic [kgug_pkg::ROUND_W-1:0] FirstRound =
		kgug_pkg::ROUND_W'(kgug_pkg::NUM_ROUNDS);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ROUND = 2'd1;
	localparam logic [1:0] ST_CHECK = 2'd2;

	logic [1:0]                    st_q;
	logic [kgug_pkg::ROUND_W-1:0]  round_q;
	logic [PermW-1:0]              perm_q;
	kgug_pkg::gimli_state_t        state_q;
	kgug_pkg::gimli_state_t        state_next;
	kgug_pkg::gimli_state_t        load_state;
	logic                          uid_valid_q;
	logic [63:0]                   uid_low_q;
	logic [31:0]                   uid_high_q;
	logic                          below_limit;

	kgug_round u_round (
		.state_in  (state_q),
		.round     (round_q),
		.state_out (state_next)
	);

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			load_state[2*i]   = cfg.key[i][31:0];
			load_state[2*i+1] = cfg.key[i][63:32];
		end
		load_state[8]  = event_number[63:32];
		load_state[9]  = event_number[31:0];
		load_state[10] = session_number;
		load_state[11] = board_number;
	end

	assign below_limit = {state_q[2], state_q[1], state_q[0]} < {cfg.limit_high, cfg.limit_low};

	assign busy      = (st_q != ST_IDLE);
	assign uid_valid = uid_valid_q;
	assign uid_low   = uid_low_q;
	assign uid_high  = uid_high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			round_q     <= '0;
			perm_q      <= '0;
			uid_valid_q <= 1'b0;
		end else begin
			uid_valid_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (start) begin
						st_q    <= ST_ROUND;
						round_q <= FirstRound;
						perm_q  <= '0;
					end
				end
				ST_ROUND: begin
					if (round_q == kgug_pkg::ROUND_W'(1)) begin
						st_q <= ST_CHECK;
					end else begin
						round_q <= round_q - kgug_pkg::ROUND_W'(1);
					end
				end
				ST_CHECK: begin
					// Stop when the identifier is in range or the repetition cap is reached.
					if (below_limit || perm_q == LastPerm) begin
						st_q        <= ST_IDLE;
						uid_valid_q <= 1'b1;
					end else begin
						st_q    <= ST_ROUND;
						round_q <= FirstRound;
						perm_q  <= perm_q + PermW'(1);
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && start) begin
			state_q <= load_state;
		end else if (st_q == ST_ROUND) begin
			state_q <= state_next;
		end
		if (st_q == ST_CHECK) begin
			uid_low_q  <= {state_q[1], state_q[0]};
			uid_high_q <= state_q[2];
		end
	end

	a_valid_after_check: assert property (@(posedge clk) disable iff (!arst_n)
		uid_valid |-> ($past(st_q) == ST_CHECK))
		else $error("result strobe without a preceding check cycle");

	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_ROUND) |-> (round_q != '0 && round_q <= FirstRound))
		else $error("round counter out of range");

	a_start_begins: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (st_q == ST_ROUND && round_q == FirstRound))
		else $error("accepted request did not start a permutation");

	a_valid_idle: assert property (@(posedge clk) disable iff (!arst_n)
		uid_valid |-> !busy)
		else $error("result strobe while still busy");

endmodule

### design/keyed_gimli_uid_generator_top.sv
// Keyed identifier generator: each request loads the 256-bit key, the event, session and
// board numbers into a Gimli state, runs the 24-round permutation one round per cycle on a
// single shared round unit, and checks the 96-bit identifier against the configured limit in
// a separate check state, repeating the permutation until the identifier is below the limit
// or MaxPerms permutations have run, so that a request runs 1 to MaxPerms permutations. Busy
// stays high from the accepting edge to the result strobe and falls in the cycle that
// uid_valid is high. The result is shown for that single cycle only and the receiver cannot
// stall it, so it must capture uid_low and uid_high whenever uid_valid is high. Configuration
// writes are always ready and must only be made while busy is low.
module keyed_gimli_uid_generator_top #(
	parameter int unsigned MaxPerms = kgug_pkg::MAX_PERMS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [kgug_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [63:0]                     cfg_data,
	input  logic                            start,
	output logic                            busy,
	input  logic [63:0]                     event_number,
	input  logic [31:0]                     session_number,
	input  logic [31:0]                     board_number,
	output logic                            uid_valid,
	output logic [63:0]                     uid_low,
	output logic [31:0]                     uid_high
);

	kgug_pkg::cfg_t cfg;

	kgug_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	kgug_core #(
		.MaxPerms (MaxPerms)
	) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.start          (start),
		.busy           (busy),
		.event_number   (event_number),
		.session_number (session_number),
		.board_number   (board_number),
		.uid_valid      (uid_valid),
		.uid_low        (uid_low),
		.uid_high       (uid_high)
	);

endmodule
